FILE: rtl/ttc_pkg.sv
// ttc_pkg: shared types and constants for the tilt-compensated compass core.
// Payload structs, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ttc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FOV_BITS    = 15;
	localparam int ANGLE_BITS  = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int TABLE_LEN   = 24;

	localparam logic [15:0] WEIGHT_LO   = 16'd655;
	localparam logic [12:0] WEIGHT_SPAN = 13'd5899;
	localparam logic [14:0] FOV_FULL    = 15'd23666;
	localparam logic [15:0] GAIN_INV    = 16'd39797;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic signed [SAMPLE_BITS-1:0] mag_x;
		logic signed [SAMPLE_BITS-1:0] mag_y;
		logic signed [SAMPLE_BITS-1:0] mag_z;
		logic                          sample_ok;
		logic [FOV_BITS-1:0]           field_of_view;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll_angle;
		logic signed [ANGLE_BITS-1:0] pitch_angle;
		logic signed [ANGLE_BITS-1:0] yaw_angle;
	} angle_t;

	// launch request for the shared CORDIC
	typedef struct packed {
		logic start;
		logic rotate;
	} cordic_req_t;

	// atan(2^-i), full turn = 2^32
	localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage
`default_nettype wire

FILE: rtl/ttc_wgt.sv
// ttc_wgt: filter weight from field of view, bit-serial restoring divide by 130 deg.
// Uses ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttc_wgt
	import ttc_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire [FOV_BITS-1:0]      fov,
	output logic                    done,
	output logic [WEIGHT_BITS-1:0]  weight
);

	localparam int NUM_BITS = 28;

	logic [NUM_BITS-1:0] num_q;
	logic [15:0]         rem_q;
	logic [4:0]          cnt_q;
	logic                run_q;
	logic                done_q;

	logic [FOV_BITS-1:0] fov_c;
	logic [NUM_BITS-1:0] num_init;
	logic [15:0]         trial;
	logic                ge;

	always_comb begin
		fov_c    = (fov > FOV_FULL) ? FOV_FULL : fov;
		num_init = NUM_BITS'(WEIGHT_SPAN) * NUM_BITS'(fov_c) + NUM_BITS'(FOV_FULL >> 1);
		trial    = {rem_q[14:0], num_q[NUM_BITS-1]};
		ge       = trial >= 16'(FOV_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				num_q <= num_init;
				rem_q <= '0;
			end else if (run_q) begin
				rem_q <= ge ? (trial - 16'(FOV_FULL)) : trial;
				num_q <= {num_q[NUM_BITS-2:0], ge};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(NUM_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign weight = WEIGHT_LO + 16'(num_q[12:0]);

endmodule
`default_nettype wire

FILE: rtl/ttc_mul.sv
// ttc_mul: bit-serial signed by Q0.16 multiply with round-half-up, one weight bit a cycle.
// Uses ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttc_mul
	import ttc_pkg::*;
#(
	parameter int AW = 38
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire signed [AW-1:0]    a,
	input  wire [WEIGHT_BITS-1:0]  k,
	output logic                   done,
	output logic signed [AW-1:0]   p
);

	localparam int PW = AW + WEIGHT_BITS + 1;

	logic signed [PW-1:0]     acc_q;
	logic signed [AW-1:0]     a_q;
	logic [WEIGHT_BITS-1:0]   k_q;
	logic [4:0]               cnt_q;
	logic                     run_q;
	logic                     done_q;
	logic signed [PW-1:0]     rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				a_q   <= a;
				k_q   <= k;
				acc_q <= '0;
			end else if (run_q) begin
				// MSB first: acc = 2*acc + bit*a
				acc_q <= (acc_q <<< 1) + (k_q[WEIGHT_BITS-1] ? PW'(a_q) : PW'(0));
				k_q   <= {k_q[WEIGHT_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(WEIGHT_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rnd  = acc_q + PW'(1 << (WEIGHT_BITS - 1));
	assign p    = AW'(rnd >>> WEIGHT_BITS);
	assign done = done_q;

endmodule
`default_nettype wire

FILE: rtl/ttc_cordic.sv
// ttc_cordic: shared iterative CORDIC, vectoring and rotation, one step a cycle.
// Uses ttc_pkg (arctangent table, request struct).
`timescale 1ns / 1ps
`default_nettype none
module ttc_cordic
	import ttc_pkg::*;
#(
	parameter int CW    = 38,
	parameter int STEPS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cordic_req_t          req,
	input  wire signed [CW-1:0]  x_in,
	input  wire signed [CW-1:0]  y_in,
	input  wire [31:0]           ang_in,
	output logic                 done,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic [31:0]          z_out
);

	localparam int NSTEP = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
	localparam logic signed [32:0] QTR  = 33'sh040000000;
	localparam logic signed [32:0] HALF = 33'sh080000000;

	logic signed [CW-1:0] x_q, y_q;
	logic signed [32:0]   z_q;
	logic [4:0]           i_q;
	logic                 run_q, done_q, rot_q, zero_q;

	logic signed [CW-1:0] xs, ys;
	logic signed [32:0]   t, za;
	logic                 cw;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		t  = 33'(ATAN_TAB[i_q]);
		cw = rot_q ? z_q[32] : !y_q[CW-1];
		za = {ang_in[31], ang_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				i_q    <= '0;
				rot_q  <= req.rotate;
				zero_q <= !req.rotate && x_in == '0 && y_in == '0;
				if (req.rotate) begin
					if (za > QTR) begin
						x_q <= -x_in; y_q <= -y_in; z_q <= za - HALF;
					end else if (za < -QTR) begin
						x_q <= -x_in; y_q <= -y_in; z_q <= za + HALF;
					end else begin
						x_q <= x_in; y_q <= y_in; z_q <= za;
					end
				end else if (x_in[CW-1]) begin
					x_q <= -x_in; y_q <= -y_in; z_q <= HALF;
				end else begin
					x_q <= x_in; y_q <= y_in; z_q <= '0;
				end
			end else if (run_q) begin
				if (cw) begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + t;
				end else begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - t;
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'(NSTEP - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = zero_q ? 32'd0 : z_q[31:0];

endmodule
`default_nettype wire

FILE: rtl/tilt_compensated_compass_core.sv
// tilt_compensated_compass_core: top level of the tilt-compensated compass.
// Uses ttc_pkg, ttc_wgt, ttc_mul, ttc_cordic.
//
// Channel   Direction  Handshake              Payload
// sample    in         sample_valid/ready     sample_t (raw accel, mag, ok, fov)
// angle     out        angle_valid/ready      angle_t (roll, pitch, yaw)
// config    in         APB psel/penable       enabled at byte address 0
//
// A transaction that produces angles passes through the weight divider (launch,
// 28 quotient bits, done), six serial filter multiplies (skipped on the first
// sample), five CORDIC passes and four serial gain multiplies. A dropped
// transaction leaves the sequencer in idle. arst_n clears control state and the
// filter. A finished result waits in the output register; the next transaction
// is taken meanwhile, and the sequencer stalls only when it must hand over a new
// result.
`timescale 1ns / 1ps
`default_nettype none
module tilt_compensated_compass_core
	import ttc_pkg::*;
#(
	parameter int FRACTION_BITS = 16,
	parameter int CORDIC_STEPS  = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        angle_valid,
	input  wire         angle_ready,
	output angle_t      angle,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [2:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int W  = SAMPLE_BITS + FRACTION_BITS;  // filter state width
	localparam int CW = W + 6;                         // CORDIC headroom

	typedef enum logic [4:0] {
		S_IDLE, S_WGT, S_FMUL, S_FWAIT,
		S_V1, S_V1W, S_G1, S_G1W, S_V2, S_V2W,
		S_R1, S_R1W, S_G2, S_G2W, S_G3, S_G3W,
		S_R2, S_R2W, S_G4, S_G4W, S_V3, S_V3W, S_OUT
	} state_t;

	state_t state_q;

	logic                   enabled_q, started_q;
	logic signed [SAMPLE_BITS-1:0] smp_q [6];
	logic [FOV_BITS-1:0]    fov_q;
	logic signed [W-1:0]    filt_q [6];     // accel x,y,z then mag x,y,z
	logic [2:0]             idx_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic signed [CW-1:0]   r_q, m0_q, m1_q, m2_q;
	logic [31:0]            roll_q, pitch_q, yaw_q;
	logic                   angle_valid_q;
	angle_t                 angle_q;

	// config port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, enabled_q} : 32'd0;

	// sample helpers
	logic signed [SAMPLE_BITS-1:0] smp_in [6];
	assign smp_in[0] = sample.accel_x;
	assign smp_in[1] = sample.accel_y;
	assign smp_in[2] = sample.accel_z;
	assign smp_in[3] = sample.mag_x;
	assign smp_in[4] = sample.mag_y;
	assign smp_in[5] = sample.mag_z;

	function automatic logic signed [W-1:0] to_q(input logic signed [SAMPLE_BITS-1:0] s);
		to_q = W'(s) <<< FRACTION_BITS;
	endfunction

	function automatic logic signed [CW-1:0] ext(input logic signed [W-1:0] v);
		ext = CW'(v);
	endfunction

	function automatic logic [ANGLE_BITS-1:0] to_out(input logic [31:0] z);
		logic [31:0] t;
		t      = z + 32'h0000_8000;
		to_out = t[31:16];
	endfunction

	// units
	logic                   wgt_start, wgt_done;
	logic [WEIGHT_BITS-1:0] wgt_val;

	ttc_wgt u_wgt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wgt_start),
		.fov    (fov_q),
		.done   (wgt_done),
		.weight (wgt_val)
	);

	logic                   mul_start, mul_done;
	logic signed [CW-1:0]   mul_a, mul_p;
	logic [WEIGHT_BITS-1:0] mul_k;

	ttc_mul #(.AW(CW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.k      (mul_k),
		.done   (mul_done),
		.p      (mul_p)
	);

	cordic_req_t          cor_req;
	logic                 cor_done;
	logic signed [CW-1:0] cor_x, cor_y, cor_xo, cor_yo;
	logic [31:0]          cor_a, cor_z;

	ttc_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.x_in   (cor_x),
		.y_in   (cor_y),
		.ang_in (cor_a),
		.done   (cor_done),
		.x_out  (cor_xo),
		.y_out  (cor_yo),
		.z_out  (cor_z)
	);

	logic sample_fire;
	logic out_load;
	assign sample_ready = (state_q == S_IDLE);
	assign sample_fire  = sample_valid && sample_ready;
	assign wgt_start    = (state_q == S_WGT) && !wgt_done && idx_q == 3'd7;
	// hand over only once the output register is free
	assign out_load     = (state_q == S_OUT) && (!angle_valid_q || angle_ready);

	// operand selection for the shared units
	always_comb begin
		mul_start = 1'b0;
		mul_a     = cor_xo;
		mul_k     = GAIN_INV;
		cor_req   = '{start: 1'b0, rotate: 1'b0};
		cor_x     = ext(filt_q[1]);
		cor_y     = -ext(filt_q[0]);
		cor_a     = 32'd0;
		unique case (state_q)
			S_FMUL: begin
				mul_start = 1'b1;
				mul_a     = ext(to_q(smp_q[idx_q])) - ext(filt_q[idx_q]);
				mul_k     = w_q;
			end
			S_G1, S_G2: mul_start = 1'b1;
			S_G3, S_G4: begin
				mul_start = 1'b1;
				mul_a     = cor_yo;
			end
			S_V1: cor_req.start = 1'b1;
			S_V2: begin
				cor_req.start = 1'b1;
				cor_x         = r_q;
				cor_y         = -ext(filt_q[2]);
			end
			S_R1: begin
				cor_req = '{start: 1'b1, rotate: 1'b1};
				cor_x   = ext(filt_q[3]);
				cor_y   = ext(filt_q[4]);
				cor_a   = 32'd0 - roll_q;
			end
			S_R2: begin
				cor_req = '{start: 1'b1, rotate: 1'b1};
				cor_x   = m1_q;
				cor_y   = ext(filt_q[5]);
				cor_a   = pitch_q;
			end
			S_V3: begin
				cor_req.start = 1'b1;
				cor_x         = -m2_q;
				cor_y         = -m0_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			enabled_q     <= 1'b0;
			started_q     <= 1'b0;
			angle_valid_q <= 1'b0;
			idx_q         <= '0;
			for (int i = 0; i < 6; i++) filt_q[i] <= '0;
		end else begin
			if (cfg_wr && paddr[2] == 1'b0) enabled_q <= pwdata[0];
			if (out_load) begin
				angle_valid_q <= 1'b1;
			end else if (angle_valid_q && angle_ready) begin
				angle_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample_fire && sample.sample_ok && (enabled_q || started_q)) begin
						if (!enabled_q) begin
							started_q <= 1'b0;
						end else begin
							for (int i = 0; i < 6; i++) smp_q[i] <= smp_in[i];
							fov_q   <= sample.field_of_view;
							idx_q   <= 3'd7;   // marks divider launch pending
							state_q <= S_WGT;
						end
					end
				end
				S_WGT: begin
					idx_q <= '0;
					if (wgt_done) begin
						w_q <= wgt_val;
						if (started_q) begin
							state_q <= S_FMUL;
						end else begin
							for (int i = 0; i < 6; i++) filt_q[i] <= to_q(smp_q[i]);
							state_q <= S_V1;
						end
						started_q <= 1'b1;
					end
				end
				S_FMUL: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (mul_done) begin
						filt_q[idx_q] <= filt_q[idx_q] + W'(mul_p);
						idx_q         <= idx_q + 3'd1;
						state_q       <= (idx_q == 3'd5) ? S_V1 : S_FMUL;
					end
				end
				S_V1: state_q <= S_V1W;
				S_V1W: if (cor_done) begin
					roll_q  <= cor_z;
					state_q <= S_G1;
				end
				S_G1: state_q <= S_G1W;
				S_G1W: if (mul_done) begin
					r_q     <= mul_p;
					state_q <= S_V2;
				end
				S_V2: state_q <= S_V2W;
				S_V2W: if (cor_done) begin
					pitch_q <= cor_z;
					state_q <= S_R1;
				end
				S_R1: state_q <= S_R1W;
				S_R1W: if (cor_done) state_q <= S_G2;
				S_G2: state_q <= S_G2W;
				S_G2W: if (mul_done) begin
					m0_q    <= mul_p;
					state_q <= S_G3;
				end
				S_G3: state_q <= S_G3W;
				S_G3W: if (mul_done) begin
					m1_q    <= mul_p;
					state_q <= S_R2;
				end
				S_R2: state_q <= S_R2W;
				S_R2W: if (cor_done) state_q <= S_G4;
				S_G4: state_q <= S_G4W;
				S_G4W: if (mul_done) begin
					m2_q    <= mul_p;
					state_q <= S_V3;
				end
				S_V3: state_q <= S_V3W;
				S_V3W: if (cor_done) begin
					yaw_q   <= cor_z;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						angle_q.roll_angle  <= to_out(roll_q);
						angle_q.pitch_angle <= to_out(pitch_q);
						angle_q.yaw_angle   <= to_out(yaw_q);
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign angle_valid = angle_valid_q;
	assign angle       = angle_q;

endmodule
`default_nettype wire

FILE: rtl/ttc_chk.sv
// ttc_chk: port-level checks for the compass core, bound to the top level.
// Uses ttc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttc_chk
	import ttc_pkg::*;
(
	input wire         clk,
	input wire         arst_n,
	input wire         sample_valid,
	input wire         sample_ready,
	input sample_t     sample,
	input wire         angle_valid,
	input wire         angle_ready,
	input angle_t      angle,
	input wire         psel,
	input wire         penable,
	input wire         pwrite,
	input wire [2:0]   paddr,
	input wire [31:0]  pwdata,
	input wire [31:0]  prdata,
	input wire         pready
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && !angle_ready |=> angle_valid && $stable(angle))
		else $error("stalled result changed");

	// no result can rise in the cycle after an accepted sample
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !$rose(angle_valid))
		else $error("result too early");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_prdata: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:1] == 31'd0)
		else $error("reserved read bits set");

endmodule

bind tilt_compensated_compass_core ttc_chk u_ttc_chk (.*);
`default_nettype wire

FILE: tb/ttc_angle_checker.sv
// ttc_angle_checker: watches the sample, angle and APB ports of the compass core,
// predicts roll, pitch and yaw per sample transaction and compares them in order.
// Depends on ttc_pkg for the payload types and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module ttc_angle_checker
	import ttc_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         sample_valid,
	input  wire         sample_ready,
	input  sample_t     sample,
	input  wire         angle_valid,
	input  wire         angle_ready,
	input  angle_t      angle,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [2:0]   paddr,
	input  wire [31:0]  pwdata,
	input  wire         pready,
	output int          pending,
	output int          fail_count,
	output int          samples_taken,
	output int          angles_checked
);

	localparam logic [2:0] ADDR_ENABLED = 3'd0;

	logic   fusion_on;
	logic   have_start;
	longint filt_acc [3];
	longint filt_mag [3];
	angle_t expected_angles [$];

	// a * k / 2^16 with round-half-up on the fraction part
	function automatic longint gain_mul(longint a, longint k);
		longint q, r;
		q = a >>> 16;
		r = a - q * 65536;
		return q * k + ((r * k + 32768) >>> 16);
	endfunction

	function automatic logic [31:0] heading_of(longint y, longint x, output longint len);
		logic [31:0] z;
		longint xs, ys;
		z = 32'd0;
		len = 0;
		if (x == 0 && y == 0)
			return 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end
		end
		len = gain_mul(x, GAIN_INV);
		return z;
	endfunction

	function automatic void spin(logic [31:0] a, inout longint x, inout longint y);
		longint z, xs, ys;
		z = longint'($signed(a));
		if (z > 64'sh4000_0000) begin
			x = -x; y = -y; z -= 64'sh8000_0000;
		end else if (z < -64'sh4000_0000) begin
			x = -x; y = -y; z += 64'sh8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
			end
		end
		x = gain_mul(x, GAIN_INV);
		y = gain_mul(y, GAIN_INV);
	endfunction

	function automatic logic [15:0] to_angle(logic [31:0] z);
		logic [31:0] t;
		t = z + 32'h8000;
		return t[31:16];
	endfunction

	// filter update and orientation for one sample; returns 1 when angles are due
	function automatic bit orient(sample_t s, output angle_t res);
		longint acc [3], mg [3], len, fov, w, dummy;
		logic [31:0] roll, pitch, yaw;
		res = '0;
		if (!fusion_on && !have_start) return 0;
		if (!s.sample_ok) return 0;
		if (!fusion_on) begin
			have_start = 0;
			return 0;
		end
		acc[0] = longint'(s.accel_x) * 65536;
		acc[1] = longint'(s.accel_y) * 65536;
		acc[2] = longint'(s.accel_z) * 65536;
		mg[0]  = longint'(s.mag_x) * 65536;
		mg[1]  = longint'(s.mag_y) * 65536;
		mg[2]  = longint'(s.mag_z) * 65536;
		fov = longint'(s.field_of_view);
		if (fov > longint'(FOV_FULL)) fov = longint'(FOV_FULL);
		w = longint'(WEIGHT_LO)
			+ (longint'(WEIGHT_SPAN) * fov + longint'(FOV_FULL) / 2) / longint'(FOV_FULL);
		for (int i = 0; i < 3; i++) begin
			if (have_start) begin
				filt_acc[i] += gain_mul(acc[i] - filt_acc[i], w);
				filt_mag[i] += gain_mul(mg[i] - filt_mag[i], w);
			end else begin
				filt_acc[i] = acc[i];
				filt_mag[i] = mg[i];
			end
		end
		have_start = 1;
		roll  = heading_of(-filt_acc[0], filt_acc[1], len);
		pitch = heading_of(-filt_acc[2], len, dummy);
		mg[0] = filt_mag[0];
		mg[1] = filt_mag[1];
		mg[2] = filt_mag[2];
		spin(32'd0 - roll, mg[0], mg[1]);
		spin(pitch, mg[1], mg[2]);
		yaw = heading_of(-mg[0], -mg[2], dummy);
		res.roll_angle  = to_angle(roll);
		res.pitch_angle = to_angle(pitch);
		res.yaw_angle   = to_angle(yaw);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angle_t due, want;
		if (!arst_n) begin
			fusion_on = 0;
			have_start = 0;
			for (int i = 0; i < 3; i++) begin
				filt_acc[i] = 0;
				filt_mag[i] = 0;
			end
			expected_angles.delete();
			pending = 0;
			fail_count = 0;
			samples_taken = 0;
			angles_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ENABLED)
				fusion_on = pwdata[0];
			if (sample_valid && sample_ready) begin
				samples_taken++;
				if (orient(sample, due))
					expected_angles.push_back(due);
			end
			if (angle_valid && angle_ready) begin
				angles_checked++;
				if (expected_angles.size() == 0) begin
					$error("angle transaction with nothing expected: %h", angle);
					fail_count++;
				end else begin
					want = expected_angles.pop_front();
					if (angle.roll_angle !== want.roll_angle) begin
						$error("roll_angle expected %0d got %0d",
							want.roll_angle, angle.roll_angle);
						fail_count++;
					end
					if (angle.pitch_angle !== want.pitch_angle) begin
						$error("pitch_angle expected %0d got %0d",
							want.pitch_angle, angle.pitch_angle);
						fail_count++;
					end
					if (angle.yaw_angle !== want.yaw_angle) begin
						$error("yaw_angle expected %0d got %0d",
							want.yaw_angle, angle.yaw_angle);
						fail_count++;
					end
				end
			end
			pending = expected_angles.size();
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb_tilt_compensated_compass_core.sv
// tb_tilt_compensated_compass_core: stimulus and verdict for the compass core.
// Needs ttc_pkg, the core RTL and ttc_angle_checker (prediction and comparison).
// Directed corner cases first, then random phases with enable toggled between them.
`timescale 1ns / 1ps
`default_nettype none
module tb_tilt_compensated_compass_core;
	import ttc_pkg::*;

	localparam logic [2:0] ADDR_ENABLED = 3'd0;
	localparam logic [2:0] ADDR_UNUSED  = 3'd4;   // no register here, write is dropped
	localparam int         RANDOM_ITEMS = 1650;
	localparam int         LONG_HOLD    = 1500;   // receiver hold-off, in cycles
	localparam int         SETTLE       = 400;    // > one full transaction latency

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	sample_t     sample = '0;
	logic        angle_valid;
	logic        angle_ready = 1'b0;
	angle_t      angle;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int pending, fail_count, samples_taken, angles_checked;

	// sender burst bookkeeping
	int burst_left = 1;
	// long receiver hold-off request; taken once by the receiver process
	bit hold_req = 0;
	bit hold_taken = 0;

	always #6 clk = ~clk;

	tilt_compensated_compass_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.angle_valid(angle_valid), .angle_ready(angle_ready), .angle(angle),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ttc_angle_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.angle_valid(angle_valid), .angle_ready(angle_ready), .angle(angle),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.pending(pending), .fail_count(fail_count),
		.samples_taken(samples_taken), .angles_checked(angles_checked)
	);

	// Receiver: segments of always-ready, coin-flip and mostly-stalled, plus
	// one long hold-off on request so the core backs up and blocks its input.
	initial begin
		int mode, len;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(1, 60);
			repeat (len) begin
				@(posedge clk);
				if (hold_req && !hold_taken) begin
					hold_taken = 1;
					angle_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0: angle_ready <= 1'b1;
					1: angle_ready <= 1'($urandom_range(0, 1));
					default: angle_ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// Called just after a rising edge. Presents one transaction and returns at
	// the edge where it is taken or after a burst gap; valid drops only in gaps.
	task automatic offer(sample_t s);
		int gap;
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Pause the sender until every expected angle has come back, then let any
	// in-flight dropped transaction settle before touching the register.
	task automatic drain();
		sample_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] corner16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t rand_sample(bit corners, int ok_pct);
		sample_t s;
		s.accel_x = corners ? corner16() : 16'($urandom);
		s.accel_y = corners ? corner16() : 16'($urandom);
		s.accel_z = corners ? corner16() : 16'($urandom);
		s.mag_x   = corners ? corner16() : 16'($urandom);
		s.mag_y   = corners ? corner16() : 16'($urandom);
		s.mag_z   = corners ? corner16() : 16'($urandom);
		s.sample_ok = ($urandom_range(0, 99) < ok_pct);
		case ($urandom_range(0, 7))
			0: s.field_of_view = '0;
			1: s.field_of_view = FOV_FULL;
			2: s.field_of_view = 15'h7FFF;
			3: s.field_of_view = 15'($urandom_range(0, 23666));
			default: s.field_of_view = 15'($urandom);
		endcase
		return s;
	endfunction

	function automatic sample_t make(logic signed [15:0] v, logic ok, logic [14:0] fov);
		sample_t s;
		s.accel_x = v; s.accel_y = v; s.accel_z = v;
		s.mag_x = v; s.mag_y = v; s.mag_z = v;
		s.sample_ok = ok;
		s.field_of_view = fov;
		return s;
	endfunction

	initial begin
		int counted, phase_len;
		bit fusion;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: disabled and never started, so both are dropped
		offer(make(16'sh1234, 1'b1, 15'd100));
		offer(make(16'sh1234, 1'b0, 15'd100));
		drain();
		apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
		apb_write(ADDR_ENABLED, 32'd1);

		// first sample loads straight in; zero vector gives zero angles
		offer(make(16'sh0000, 1'b1, 15'd0));
		offer(make(16'sh7FFF, 1'b1, 15'd0));
		offer(make(-16'sh8000, 1'b1, FOV_FULL));
		offer(make(16'sh7FFF, 1'b1, 15'h7FFF));
		offer(make(-16'sh0001, 1'b1, 15'd11833));
		offer(make(16'sh4000, 1'b0, 15'h7FFF));      // failed read, no effect
		repeat (10) offer(rand_sample(1, 90));
		drain();

		// disabled after start: failed read keeps the start flag, good read clears it
		apb_write(ADDR_ENABLED, 32'd0);
		offer(make(16'sh0100, 1'b0, 15'd5));
		offer(make(16'sh0100, 1'b1, 15'd5));
		offer(make(16'sh0100, 1'b1, 15'd5));
		drain();
		apb_write(ADDR_ENABLED, 32'd1);
		offer(make(-16'sh0200, 1'b1, 15'd3000));      // reloads directly
		offer(rand_sample(1, 100));

		// --- random phases; the first one carries the long receiver hold-off
		counted = 0;
		fusion = 1;
		hold_req = 1;
		while (counted < RANDOM_ITEMS) begin
			phase_len = fusion ? $urandom_range(60, 300) : $urandom_range(4, 15);
			if (fusion && phase_len > RANDOM_ITEMS - counted)
				phase_len = RANDOM_ITEMS - counted;
			repeat (phase_len) begin
				offer(rand_sample($urandom_range(0, 9) == 0, 92));
				if (fusion) counted++;
			end
			drain();
			fusion = ($urandom_range(0, 3) != 0) || !fusion;
			apb_write(ADDR_ENABLED, {31'd0, fusion});
		end
		drain();

		$display("transactions sent %0d, angle results checked %0d, %0d mismatches",
			samples_taken, angles_checked, fail_count);
		$display("covered field extremes, fov clamp, failed reads, enable toggling, stalls");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
